// ----- hw/rtl/bounded_stack_parity_partition_core_macros.svh -----
// Assertion macros shared by the stack core RTL.
`ifndef BOUNDED_STACK_PARITY_PARTITION_CORE_MACROS_SVH
`define BOUNDED_STACK_PARITY_PARTITION_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BSPP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("bspp assertion failed");

// Next-cycle implication, checked out of reset.
`define BSPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("bspp assertion failed");

`endif

// ----- hw/rtl/bspp_pkg.sv -----
// Package: types and constants of the bounded stack core.
package bspp_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int CAP_W          = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_PART = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_RD,
		S_PART_ODD,
		S_PART_EVEN,
		S_PART_COPY
	} state_t;

endpackage

// ----- hw/rtl/bspp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bspp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/bounded_stack_parity_partition_core.sv -----
// Bounded LIFO stack core with in-place stable parity partition.
// Each RAM has a single read port. A partition makes two passes over the stack RAM, odd entries
// then even entries, appending them to the scratch RAM, then one copy pass back into the stack.
// One item in flight; busy drops in the result beat's cycle, so the next command can be
// accepted on the edge that ends it: no new command is taken until the current one finishes.
// Reset clears the fill count and control; capacity resets to 16; RAM contents are kept.
`include "bounded_stack_parity_partition_core_macros.svh"

module bounded_stack_parity_partition_core #(
	parameter int DEPTH      = bspp_pkg::DEPTH_DEF,
	parameter int WORD_WIDTH = bspp_pkg::WORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic [bspp_pkg::CAP_W-1:0]   cfg_wdata,
	// command side
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   command,
	input  logic [WORD_WIDTH-1:0]        push_value,
	// result side
	output logic                         done,
	output logic [WORD_WIDTH-1:0]        pop_value,
	output logic [1:0]                   status,
	output logic [$clog2(DEPTH+1)-1:0]   entry_count
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > bspp_pkg::CAP_W) ? CW : bspp_pkg::CAP_W;

	bspp_pkg::state_t  state_q, state_d;
	bspp_pkg::cmd_t    cmd_q;
	bspp_pkg::status_t res_status_q, fin_status;

	logic [WORD_WIDTH-1:0]      val_q, res_value_q, fin_value;
	logic [bspp_pkg::CAP_W-1:0] cap_q;
	logic [CW-1:0]              fill_q, fill_d, fill_dec;
	logic [CW-1:0]              idx_q, idx_d, wr_q, wr_d, res_count_q;
	logic                       rv_s1, rv_d;
	logic [AW-1:0]              ad_s1;
	logic                       fin, accept, idx_lt, pass_end, full, odd_pass;
	logic [CMPW-1:0]            cap_ext, eff_cap;

	logic                  stk_we, stk_re, scr_we, scr_re;
	logic [AW-1:0]         stk_waddr, stk_raddr, scr_waddr, scr_raddr;
	logic [WORD_WIDTH-1:0] stk_wdata, stk_rdata, scr_wdata, scr_rdata;

	assign accept   = start && !busy;
	assign busy     = (state_q != bspp_pkg::S_IDLE);
	assign idx_lt   = (idx_q < fill_q);
	assign pass_end = !idx_lt && !rv_s1;
	assign fill_dec = fill_q - CW'(1);
	assign odd_pass = (state_q == bspp_pkg::S_PART_ODD);

	// effective capacity: register saturated to 1..DEPTH
	always_comb begin
		cap_ext = CMPW'(cap_q);
		if (cap_ext == '0) begin
			eff_cap = CMPW'(1);
		end else if (cap_ext > CMPW'(DEPTH)) begin
			eff_cap = CMPW'(DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end
	assign full = (CMPW'(fill_q) >= eff_cap);

	// stack and scratch storage
	bspp_ram #(.WIDTH(WORD_WIDTH), .DEPTH(DEPTH)) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (stk_re),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	bspp_ram #(.WIDTH(WORD_WIDTH), .DEPTH(DEPTH)) u_scratch_ram (
		.clk  (clk),
		.we   (scr_we),
		.waddr(scr_waddr),
		.wdata(scr_wdata),
		.re   (scr_re),
		.raddr(scr_raddr),
		.rdata(scr_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bspp_pkg::S_IDLE: begin
				if (accept) state_d = bspp_pkg::S_EXEC;
			end
			bspp_pkg::S_EXEC: begin
				unique case (cmd_q)
					bspp_pkg::CMD_POP: begin
						state_d = (fill_q == '0) ? bspp_pkg::S_IDLE : bspp_pkg::S_POP_RD;
					end
					bspp_pkg::CMD_PART: begin
						state_d = (fill_q == '0) ? bspp_pkg::S_IDLE : bspp_pkg::S_PART_ODD;
					end
					bspp_pkg::CMD_PUSH, bspp_pkg::CMD_NOP: state_d = bspp_pkg::S_IDLE;
				endcase
			end
			bspp_pkg::S_POP_RD: state_d = bspp_pkg::S_IDLE;
			bspp_pkg::S_PART_ODD: begin
				if (pass_end) state_d = bspp_pkg::S_PART_EVEN;
			end
			bspp_pkg::S_PART_EVEN: begin
				if (pass_end) state_d = bspp_pkg::S_PART_COPY;
			end
			bspp_pkg::S_PART_COPY: begin
				if (pass_end) state_d = bspp_pkg::S_IDLE;
			end
			default: state_d = bspp_pkg::S_IDLE;
		endcase
	end

	// datapath and RAM control per state
	always_comb begin
		stk_we     = 1'b0;
		stk_waddr  = ad_s1;
		stk_wdata  = scr_rdata;
		stk_re     = 1'b0;
		stk_raddr  = idx_q[AW-1:0];
		scr_we     = 1'b0;
		scr_waddr  = wr_q[AW-1:0];
		scr_wdata  = stk_rdata;
		scr_re     = 1'b0;
		scr_raddr  = idx_q[AW-1:0];
		fill_d     = fill_q;
		idx_d      = idx_q;
		wr_d       = wr_q;
		rv_d       = 1'b0;
		fin        = 1'b0;
		fin_value  = '0;
		fin_status = bspp_pkg::STAT_OK;
		unique case (state_q)
			bspp_pkg::S_IDLE: begin
			end
			bspp_pkg::S_EXEC: begin
				unique case (cmd_q)
					bspp_pkg::CMD_PUSH: begin
						fin = 1'b1;
						if (full) begin
							fin_status = bspp_pkg::STAT_FULL;
						end else begin
							stk_we    = 1'b1;
							stk_waddr = fill_q[AW-1:0];
							stk_wdata = val_q;
							fill_d    = fill_q + CW'(1);
						end
					end
					bspp_pkg::CMD_POP: begin
						if (fill_q == '0) begin
							fin        = 1'b1;
							fin_value  = '1;
							fin_status = bspp_pkg::STAT_EMPTY;
						end else begin
							stk_re    = 1'b1;
							stk_raddr = fill_dec[AW-1:0];
							fill_d    = fill_dec;
						end
					end
					bspp_pkg::CMD_PART: begin
						fin   = (fill_q == '0);
						idx_d = '0;
						wr_d  = '0;
					end
					bspp_pkg::CMD_NOP: fin = 1'b1;
				endcase
			end
			bspp_pkg::S_POP_RD: begin
				fin       = 1'b1;
				fin_value = stk_rdata;
			end
			bspp_pkg::S_PART_ODD, bspp_pkg::S_PART_EVEN: begin
				// read stack in order, append matching parity to scratch
				rv_d = idx_lt;
				if (idx_lt) begin
					stk_re = 1'b1;
					idx_d  = idx_q + CW'(1);
				end
				if (rv_s1 && (stk_rdata[0] == odd_pass)) begin
					scr_we = 1'b1;
					wr_d   = wr_q + CW'(1);
				end
				if (pass_end) idx_d = '0;
			end
			bspp_pkg::S_PART_COPY: begin
				// copy scratch back into the stack, one entry per beat
				rv_d = idx_lt;
				if (idx_lt) begin
					scr_re = 1'b1;
					idx_d  = idx_q + CW'(1);
				end
				if (rv_s1) stk_we = 1'b1;
				fin = pass_end;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bspp_pkg::S_IDLE;
			cap_q   <= bspp_pkg::CAP_RESET;
			fill_q  <= '0;
			idx_q   <= '0;
			wr_q    <= '0;
			rv_s1   <= 1'b0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
			wr_q    <= wr_d;
			rv_s1   <= rv_d;
			done    <= fin;
			if (cfg_we) cap_q <= cfg_wdata;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ad_s1 <= idx_q[AW-1:0];
		if (accept) begin
			cmd_q <= bspp_pkg::cmd_t'(command);
			val_q <= push_value;
		end
		if (fin) begin
			res_value_q  <= fin_value;
			res_status_q <= fin_status;
			res_count_q  <= fill_d;
		end
	end

	assign pop_value   = res_value_q;
	assign status      = res_status_q;
	assign entry_count = res_count_q;

	`BSPP_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CW'(DEPTH))
	`BSPP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`BSPP_ASSERT_NOW(a_done_after_work, done, $past(state_q) != bspp_pkg::S_IDLE)
	`BSPP_ASSERT_NOW(a_wr_bound, odd_pass || state_q == bspp_pkg::S_PART_EVEN, wr_q <= fill_q)

endmodule

// ----- tb/stack_behavior_checker.sv -----
// Checker for the stack core: tracks commands, predicts each result beat and compares it.
module stack_behavior_checker #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bspp_pkg::CAP_W-1:0]         cfg_wdata,
	input  logic                               start,
	input  logic                               busy,
	input  logic [1:0]                         command,
	input  logic [WORD_WIDTH-1:0]              push_value,
	input  logic                               done,
	input  logic [WORD_WIDTH-1:0]              pop_value,
	input  logic [1:0]                         status,
	input  logic [$clog2(DEPTH+1)-1:0]         entry_count,
	output int                                 mismatch_count,
	output int                                 pending_count
);
	import bspp_pkg::*;

	localparam int COUNT_W = $clog2(DEPTH+1);

	typedef struct packed {
		logic [WORD_WIDTH-1:0] word;
		status_t               code;
		logic [COUNT_W-1:0]    count;
	} stack_result_t;

	// shadow copy of the stack and its settings
	logic [WORD_WIDTH-1:0] stack_words [DEPTH];
	int                    fill = 0;
	logic [CAP_W-1:0]      capacity_reg = CAP_RESET;
	stack_result_t         expected_results [$];
	int                    errors_seen = 0;
	int                    waiting = 0;

	assign mismatch_count = errors_seen;
	assign pending_count  = waiting;

	// register value saturated to 1..DEPTH
	function automatic int usable_capacity(logic [CAP_W-1:0] cap);
		int c;
		c = int'(cap);
		if (c < 1) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	// stable reorder: odd words at the bottom, even words above them
	task automatic partition_by_parity();
		logic [WORD_WIDTH-1:0] reordered [DEPTH];
		int w;
		w = 0;
		for (int i = 0; i < fill; i++) begin
			if (stack_words[i][0]) begin
				reordered[w] = stack_words[i];
				w++;
			end
		end
		for (int i = 0; i < fill; i++) begin
			if (!stack_words[i][0]) begin
				reordered[w] = stack_words[i];
				w++;
			end
		end
		for (int i = 0; i < fill; i++) stack_words[i] = reordered[i];
	endtask

	// work out the result of one accepted command beat
	task automatic apply_command(input logic [1:0] cmd, input logic [WORD_WIDTH-1:0] word);
		stack_result_t r;
		r.word = '0;
		r.code = STAT_OK;
		case (cmd_t'(cmd))
			CMD_PUSH: begin
				if (fill >= usable_capacity(capacity_reg)) begin
					r.code = STAT_FULL;
				end else begin
					stack_words[fill] = word;
					fill++;
				end
			end
			CMD_POP: begin
				if (fill == 0) begin
					r.word = '1;
					r.code = STAT_EMPTY;
				end else begin
					fill--;
					r.word = stack_words[fill];
				end
			end
			CMD_PART: partition_by_parity();
			default: ;
		endcase
		r.count = COUNT_W'(fill);
		expected_results.push_back(r);
	endtask

	// compare one result beat with the oldest prediction
	task automatic check_result();
		stack_result_t want;
		if (expected_results.size() == 0) begin
			$error("unexpected result beat: pop_value %0d status %0d entry_count %0d",
				$signed(pop_value), status, entry_count);
			errors_seen++;
			return;
		end
		want = expected_results.pop_front();
		if (pop_value !== want.word) begin
			$error("pop_value: expected %0d, got %0d", $signed(want.word), $signed(pop_value));
			errors_seen++;
		end
		if (status !== want.code) begin
			$error("status: expected %0d, got %0d", want.code, status);
			errors_seen++;
		end
		if (entry_count !== want.count) begin
			$error("entry_count: expected %0d, got %0d", want.count, entry_count);
			errors_seen++;
		end
	endtask

	// result checked before a command accepted on the same edge is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			capacity_reg = CAP_RESET;
			expected_results.delete();
		end else begin
			if (done) check_result();
			if (cfg_we) capacity_reg = cfg_wdata;
			if (start && !busy) apply_command(command, push_value);
		end
		waiting = expected_results.size();
	end

endmodule

// ----- tb/testbench.sv -----
// Testbench top: stimulus, configuration phases, watchdog and verdict for the stack core.
module testbench;
	import bspp_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int WORD_WIDTH  = WORD_WIDTH_DEF;
	localparam int COUNT_W     = $clog2(DEPTH+1);
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 13;
	localparam int PHASE_ITEMS = 150;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CAP_W-1:0]      cfg_wdata = '0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            command = CMD_PUSH;
	logic [WORD_WIDTH-1:0] push_value = '0;
	logic                  done;
	logic [WORD_WIDTH-1:0] pop_value;
	logic [1:0]            status;
	logic [COUNT_W-1:0]    entry_count;
	int                    mismatch_count;
	int                    pending_count;
	int                    stall_cycles = 0;
	int                    burst_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	bounded_stack_parity_partition_core #(
		.DEPTH(DEPTH),
		.WORD_WIDTH(WORD_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.command(command),
		.push_value(push_value),
		.done(done),
		.pop_value(pop_value),
		.status(status),
		.entry_count(entry_count)
	);

	stack_behavior_checker #(
		.DEPTH(DEPTH),
		.WORD_WIDTH(WORD_WIDTH)
	) behavior_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.command(command),
		.push_value(push_value),
		.done(done),
		.pop_value(pop_value),
		.status(status),
		.entry_count(entry_count),
		.mismatch_count(mismatch_count),
		.pending_count(pending_count)
	);

	// watchdog: too long without any beat on either side
	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// idle gap before a command: mostly none or short, a few long, some bursts with none
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// data word: mostly uniform, some extremes and small signed values
	function automatic logic [WORD_WIDTH-1:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 4))
				0: return '0;
				1: return WORD_WIDTH'(1);
				2: return {1'b0, {(WORD_WIDTH-1){1'b1}}};
				3: return {1'b1, {(WORD_WIDTH-1){1'b0}}};
				default: return '1;
			endcase
		end
		if (r == 1) return WORD_WIDTH'($urandom_range(0, 16)) - WORD_WIDTH'(8);
		return WORD_WIDTH'($urandom);
	endfunction

	// drive one command beat and hold it until accepted
	task automatic issue(input logic [1:0] cmd, input logic [WORD_WIDTH-1:0] word);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		command = cmd;
		push_value = word;
		do @(posedge clk); while (busy);
	endtask

	// drain all results, then write the capacity register
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		@(negedge clk);
		start = 1'b0;
		while (pending_count != 0) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = cap;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// one random phase at a given capacity with its own command mix
	task automatic random_phase(input logic [CAP_W-1:0] cap);
		int push_pct;
		int pop_pct;
		int r;
		set_capacity(cap);
		push_pct = $urandom_range(25, 70);
		pop_pct = $urandom_range(15, 95 - push_pct);
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < push_pct) issue(CMD_PUSH, pick_word());
			else if (r < push_pct + pop_pct) issue(CMD_POP, pick_word());
			else if ($urandom_range(0, 3) != 0) issue(CMD_PART, pick_word());
			else issue(CMD_NOP, pick_word());
		end
	endtask

	initial begin
		logic [CAP_W-1:0] cap;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty stack corner cases at reset capacity
		issue(CMD_POP, '0);
		issue(CMD_NOP, '1);
		issue(CMD_PART, '0);
		// extremes of both parities, then partition and pops
		issue(CMD_PUSH, 32'h7FFF_FFFF);
		issue(CMD_PUSH, 32'h8000_0000);
		issue(CMD_PUSH, 32'hFFFF_FFFF);
		issue(CMD_PUSH, 32'h0000_0000);
		issue(CMD_PUSH, 32'hFFFF_FFFE);
		issue(CMD_PUSH, 32'h0000_0001);
		issue(CMD_PART, '1);
		issue(CMD_NOP, '0);
		issue(CMD_POP, '1);
		issue(CMD_POP, '0);

		// capacity lowered below the fill: pushes report full until pops bring the fill below it, rest works
		set_capacity(5'd2);
		issue(CMD_PUSH, 32'h1234_5678);
		issue(CMD_PART, '0);
		issue(CMD_POP, '0);
		issue(CMD_POP, '0);
		issue(CMD_PUSH, 32'hAAAA_AAAA);
		issue(CMD_POP, '0);
		issue(CMD_PUSH, 32'h5555_5555);

		// zero register saturates to one entry
		set_capacity(5'd0);
		issue(CMD_PUSH, 32'hDEAD_BEEF);
		issue(CMD_POP, '0);
		issue(CMD_POP, '0);
		issue(CMD_PUSH, 32'h0BAD_F00D);

		// random phases sweeping the capacity, extremes first
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: cap = 5'd16;
				1: cap = 5'd31;
				2: cap = 5'd1;
				3: cap = 5'd17;
				4: cap = 5'd0;
				5: cap = 5'd3;
				default: cap = CAP_W'($urandom_range(0, 31));
			endcase
			random_phase(cap);
		end

		@(negedge clk);
		start = 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- bounded_stack_parity_partition_core.f -----
+incdir+hw/rtl
hw/rtl/bspp_pkg.sv
hw/rtl/bspp_ram.sv
hw/rtl/bounded_stack_parity_partition_core.sv
tb/stack_behavior_checker.sv
tb/testbench.sv
